FILE: design/bffa_pkg.sv
`default_nettype none

package bffa_pkg;

  localparam int MAP_BITS_DEF = 8192;

  localparam int FIELD_W = 14;
  localparam logic [FIELD_W-1:0] FIELD_MAX = 14'h3FFF;
  localparam logic [FIELD_W-1:0] LIMIT_RESET = 14'd8192;

  // commands
  localparam logic [1:0] CMD_ALLOC_INODE = 2'd0;
  localparam logic [1:0] CMD_ALLOC_BLOCK = 2'd1;
  localparam logic [1:0] CMD_FREE_INODE  = 2'd2;
  localparam logic [1:0] CMD_FREE_BLOCK  = 2'd3;

  // result status
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_RANGE = 2'd2;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_INODE_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LIMIT = 1'd1;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [FIELD_W-1:0] number;
  } in_t;

  typedef struct packed {
    logic [FIELD_W-1:0] given;
    logic [1:0]         status;
    logic [FIELD_W-1:0] free_left;
  } out_t;

endpackage

`default_nettype wire

FILE: design/bffa_map_ram.sv
`default_nettype none

module bffa_map_ram #(
  parameter int WORD_W = 64,
  parameter int DEPTH  = 128,
  parameter int AW     = 7
) (
  input  wire logic              clk,
  input  wire logic              rd_en,
  input  wire logic [AW-1:0]     rd_addr,
  output logic      [WORD_W-1:0] rd_data,
  input  wire logic              wr_en,
  input  wire logic [AW-1:0]     wr_addr,
  input  wire logic [WORD_W-1:0] wr_data
);

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: design/bffa_word_scan.sv
`default_nettype none

module bffa_word_scan #(
  parameter int WORD_W = 64,
  parameter int WB     = 6
) (
  input  wire logic [WORD_W-1:0]           word,
  input  wire logic [bffa_pkg::FIELD_W-1:0] remaining,
  output logic                             found,
  output logic      [WB-1:0]               index
);

  import bffa_pkg::*;

  logic [WORD_W-1:0] cand;

  // a bit is a candidate when clear and still below the limit
  always_comb begin
    for (int j = 0; j < WORD_W; j++) begin
      cand[j] = ~word[j] && (32'(j) < 32'(remaining));
    end
  end

  always_comb begin
    index = '0;
    for (int j = WORD_W - 1; j >= 0; j--) begin
      if (cand[j]) begin
        index = WB'(j);
      end
    end
  end

  assign found = |cand;

endmodule

`default_nettype wire

FILE: design/bitmap_first_free_allocator.sv
// Two-pool first-fit bitmap allocator, one pool for inodes and one for blocks.
// Items come in on in_valid/in_ready with a command and a 1-based number;
// each item gives exactly one result on out_valid/out_ready: the allocated
// number, a status and the free count of the addressed pool.
// Both bitmaps sit in single-port-per-direction RAMs of 64-bit words
// (8-bit words for maps under 64 bits) with a registered read.
// An allocate scans the map one word per cycle from word 0 until it finds
// a clear bit below the pool's limit or reaches the word holding the limit.
// A free is a read-modify-write of one word.
// A new item is taken once the previous result has moved into the output
// register; a stalled receiver holds the result there and the block stops
// at the end of the following item until out_ready returns.
// After reset the block clears both maps, one word per cycle, through
// every word of the map RAMs, and holds in_ready low;
// the limit registers may be written at any time while idle.
`default_nettype none

module bitmap_first_free_allocator #(
  parameter int MAP_BITS = bffa_pkg::MAP_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire bffa_pkg::in_t                    in_data,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output bffa_pkg::out_t                        out_data,
  input  wire logic                             cfg_we,
  input  wire logic [bffa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [bffa_pkg::FIELD_W-1:0]     cfg_wdata
);

  import bffa_pkg::*;

  localparam int WORD_W = (MAP_BITS >= 64) ? 64 : 8;
  localparam int WB     = $clog2(WORD_W);
  localparam int DEPTH  = (MAP_BITS + WORD_W - 1) / WORD_W;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_CHK  = 3'd3;
  localparam logic [2:0] S_FREE = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]         state_r, state_nxt;
  logic [AW-1:0]      waddr_r, waddr_nxt;
  logic [FIELD_W-1:0] base_r, base_nxt;
  logic [WB-1:0]      bit_r, bit_nxt;
  logic               is_block_r, is_block_nxt;
  logic               is_free_r, is_free_nxt;
  logic [FIELD_W-1:0] lim_r, lim_nxt;
  logic [FIELD_W-1:0] given_r, given_nxt;
  logic [1:0]         status_r, status_nxt;
  logic [FIELD_W-1:0] inode_used_r, inode_used_nxt;
  logic [FIELD_W-1:0] block_used_r, block_used_nxt;
  logic [FIELD_W-1:0] inode_limit_r, block_limit_r;
  logic               out_valid_r, out_valid_nxt;
  out_t               out_data_r, out_data_nxt;

  logic               rd_en, wr_en;
  logic [AW-1:0]      rd_addr;
  logic [WORD_W-1:0]  wr_data;
  logic [WORD_W-1:0]  inode_rd, block_rd, rd_word;

  logic [FIELD_W-1:0] in_lim_raw, in_lim;
  logic [FIELD_W-1:0] num_m1;
  logic [31:0]        num_word;
  logic [FIELD_W-1:0] remaining;
  logic               scan_found;
  logic [WB-1:0]      scan_index;
  logic [FIELD_W-1:0] pos;
  logic [FIELD_W:0]   base_end;
  logic [FIELD_W-1:0] used_cur;
  logic               last_word;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // effective limit of the addressed pool
  assign in_lim_raw = in_data.cmd[0] ? block_limit_r : inode_limit_r;
  assign in_lim     = (32'(in_lim_raw) > MAP_BITS) ? FIELD_W'(MAP_BITS) : in_lim_raw;
  assign num_m1     = in_data.number - FIELD_W'(1);
  assign num_word   = 32'(num_m1) >> WB;

  assign rd_word   = is_block_r ? block_rd : inode_rd;
  assign remaining = lim_r - base_r;
  assign pos       = base_r + FIELD_W'(scan_index);
  assign base_end  = {1'b0, base_r} + (FIELD_W+1)'(WORD_W);
  assign used_cur  = is_block_r ? block_used_r : inode_used_r;
  assign last_word = (waddr_r == AW'(DEPTH - 1));

  bffa_word_scan #(
    .WORD_W (WORD_W),
    .WB     (WB)
  ) u_scan (
    .word      (rd_word),
    .remaining (remaining),
    .found     (scan_found),
    .index     (scan_index)
  );

  assign rd_addr = (state_r == S_CHK) ? (waddr_r + AW'(1)) : waddr_r;

  bffa_map_ram #(
    .WORD_W (WORD_W),
    .DEPTH  (DEPTH),
    .AW     (AW)
  ) u_inode_map (
    .clk     (clk),
    .rd_en   (rd_en && !is_block_r),
    .rd_addr (rd_addr),
    .rd_data (inode_rd),
    .wr_en   (wr_en && (!is_block_r || state_r == S_CLR)),
    .wr_addr (waddr_r),
    .wr_data (wr_data)
  );

  bffa_map_ram #(
    .WORD_W (WORD_W),
    .DEPTH  (DEPTH),
    .AW     (AW)
  ) u_block_map (
    .clk     (clk),
    .rd_en   (rd_en && is_block_r),
    .rd_addr (rd_addr),
    .rd_data (block_rd),
    .wr_en   (wr_en && (is_block_r || state_r == S_CLR)),
    .wr_addr (waddr_r),
    .wr_data (wr_data)
  );

  always_comb begin
    state_nxt      = state_r;
    waddr_nxt      = waddr_r;
    base_nxt       = base_r;
    bit_nxt        = bit_r;
    is_block_nxt   = is_block_r;
    is_free_nxt    = is_free_r;
    lim_nxt        = lim_r;
    given_nxt      = given_r;
    status_nxt     = status_r;
    inode_used_nxt = inode_used_r;
    block_used_nxt = block_used_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;
    rd_en          = 1'b0;
    wr_en          = 1'b0;
    wr_data        = '0;

    unique case (state_r)
      S_CLR: begin
        wr_en = 1'b1;
        waddr_nxt = waddr_r + AW'(1);
        if (last_word) begin
          waddr_nxt = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          is_block_nxt = in_data.cmd[0];
          is_free_nxt  = in_data.cmd[1];
          lim_nxt      = in_lim;
          given_nxt    = '0;
          status_nxt   = STAT_OK;
          base_nxt     = '0;
          if (!in_data.cmd[1]) begin
            waddr_nxt = '0;
            if (in_lim == '0) begin
              status_nxt = STAT_FULL;
              state_nxt  = S_DONE;
            end else begin
              state_nxt = S_RD;
            end
          end else if (in_data.number == '0 || in_data.number > in_lim) begin
            status_nxt = STAT_RANGE;
            state_nxt  = S_DONE;
          end else begin
            waddr_nxt = num_word[AW-1:0];
            bit_nxt   = num_m1[WB-1:0];
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        rd_en     = 1'b1;
        state_nxt = is_free_r ? S_FREE : S_CHK;
      end
      S_CHK: begin
        if (scan_found) begin
          wr_en     = 1'b1;
          wr_data   = rd_word | (WORD_W'(1) << scan_index);
          given_nxt = pos + FIELD_W'(1);
          if (used_cur != FIELD_MAX) begin
            if (is_block_r) begin
              block_used_nxt = block_used_r + FIELD_W'(1);
            end else begin
              inode_used_nxt = inode_used_r + FIELD_W'(1);
            end
          end
          state_nxt = S_DONE;
        end else if (base_end >= {1'b0, lim_r}) begin
          status_nxt = STAT_FULL;
          state_nxt  = S_DONE;
        end else begin
          // fetch the next word while this one is checked
          rd_en     = 1'b1;
          waddr_nxt = waddr_r + AW'(1);
          base_nxt  = base_r + FIELD_W'(WORD_W);
        end
      end
      S_FREE: begin
        wr_en   = 1'b1;
        wr_data = rd_word & ~(WORD_W'(1) << bit_r);
        if (used_cur != '0) begin
          if (is_block_r) begin
            block_used_nxt = block_used_r - FIELD_W'(1);
          end else begin
            inode_used_nxt = inode_used_r - FIELD_W'(1);
          end
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.given     = given_r;
          out_data_nxt.status    = status_r;
          out_data_nxt.free_left = (used_cur >= lim_r) ? '0 : (lim_r - used_cur);
          state_nxt              = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLR;
      waddr_r       <= '0;
      is_block_r    <= 1'b0;
      is_free_r     <= 1'b0;
      inode_used_r  <= '0;
      block_used_r  <= '0;
      inode_limit_r <= LIMIT_RESET;
      block_limit_r <= LIMIT_RESET;
      out_valid_r   <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      waddr_r      <= waddr_nxt;
      is_block_r   <= is_block_nxt;
      is_free_r    <= is_free_nxt;
      inode_used_r <= inode_used_nxt;
      block_used_r <= block_used_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_INODE_LIMIT: inode_limit_r <= cfg_wdata;
          CFG_BLOCK_LIMIT: block_limit_r <= cfg_wdata;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    base_r     <= base_nxt;
    bit_r      <= bit_nxt;
    lim_r      <= lim_nxt;
    given_r    <= given_nxt;
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire
